@@ src/greedy_box_suppression_macros.svh @@
// Assertion macros used by the checker of the box suppression block.
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define GBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define GBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/gbs_pkg.sv @@
package gbs_pkg;

  // Field widths of the payloads.
  localparam int COORD_W = 16;
  localparam int AREA_W  = 32;
  localparam int THR_W   = 9;
  localparam int SLOT_W  = 7;

  // The overlap ratio is scaled by 256, a left shift by eight.
  localparam int IOU_SHIFT = 8;

  // Threshold after reset, in 256ths.
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  // One candidate box as it arrives.
  typedef struct packed {
    logic               frame_start;
    logic [COORD_W-1:0] box_left;
    logic [COORD_W-1:0] box_top;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
  } in_item_t;

  // The verdict on one box.
  typedef struct packed {
    logic              keep;
    logic              overflow;
    logic [SLOT_W-1:0] kept_slot;
  } out_item_t;

  // A box together with its area, as held in the chain.
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [AREA_W-1:0]  area;
  } box_t;

  // What one cell hands to the next: the candidate at the front and, two
  // cells behind it, the token that gathers the suppression verdict.
  typedef struct packed {
    logic box_vld;
    box_t box;
    logic tok_vld;
    logic tok_sup;
    box_t tok_box;
  } pkt_t;

endpackage

@@ src/gbs_cell.sv @@
module gbs_cell #(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gbs_pkg::THR_W-1:0] threshold,
  input  logic [CW-1:0]             count,
  input  gbs_pkg::pkt_t             pkt_in,
  output gbs_pkg::pkt_t             pkt_out
);
  import gbs_pkg::*;

  localparam int PROD_W = THR_W + AREA_W + 1;

  // Overlap of [a0, a0+al) and [b0, b0+bl), zero when they do not meet.
  function automatic logic [COORD_W-1:0] overlap_len(
    input logic [COORD_W-1:0] a0,
    input logic [COORD_W-1:0] al,
    input logic [COORD_W-1:0] b0,
    input logic [COORD_W-1:0] bl
  );
    logic [COORD_W-1:0] lo;
    logic [COORD_W:0]   ae;
    logic [COORD_W:0]   be;
    logic [COORD_W:0]   hi;
    lo = (a0 > b0) ? a0 : b0;
    ae = {1'b0, a0} + {1'b0, al};
    be = {1'b0, b0} + {1'b0, bl};
    hi = (ae < be) ? ae : be;
    if (hi > {1'b0, lo}) begin
      overlap_len = COORD_W'(hi - {1'b0, lo});
    end else begin
      overlap_len = '0;
    end
  endfunction

  // The kept box of this slot.
  box_t entry;

  // Stages of the overlap test against this slot's box.
  logic               s1_occ;
  logic [COORD_W-1:0] s1_iw;
  logic [COORD_W-1:0] s1_ih;
  logic [AREA_W:0]    s1_asum;
  logic               s2_occ;
  logic [AREA_W-1:0]  s2_inter;
  logic [AREA_W:0]    s2_uni;

  // Registers handed on to the next cell.
  logic box_vld;
  box_t box;
  logic tok_vld;
  logic tok_sup;
  box_t tok_box;

  logic              occ;
  logic [AREA_W-1:0] inter;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              hit;
  logic              store;

  // The slot takes part only if it holds a kept box.
  assign occ = (32'(count) > IDX);

  // Intersection area and union of the stage one results.
  assign inter = AREA_W'(s1_iw) * AREA_W'(s1_ih);

  // Suppression test: inter * 256 > threshold * union.
  assign lhs = PROD_W'({s2_inter, {IOU_SHIFT{1'b0}}});
  assign rhs = PROD_W'(threshold) * PROD_W'(s2_uni);
  assign hit = pkt_in.tok_vld & s2_occ & (lhs > rhs);

  // The first free slot takes a box that no earlier slot suppressed.
  assign store = pkt_in.tok_vld & ~pkt_in.tok_sup & (32'(count) == IDX);

  // Valid bits of the front and the token.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_vld <= 1'b0;
      tok_vld <= 1'b0;
    end else begin
      box_vld <= pkt_in.box_vld;
      tok_vld <= pkt_in.tok_vld;
    end
  end

  // Datapath stages, the hand-over payload and the slot's box.
  always_ff @(posedge clk) begin
    s1_occ   <= occ;
    s1_iw    <= overlap_len(pkt_in.box.left, pkt_in.box.width,
                            entry.left, entry.width);
    s1_ih    <= overlap_len(pkt_in.box.top, pkt_in.box.height,
                            entry.top, entry.height);
    s1_asum  <= {1'b0, pkt_in.box.area} + {1'b0, entry.area};
    s2_occ   <= s1_occ;
    s2_inter <= inter;
    s2_uni   <= s1_asum - {1'b0, inter};
    box      <= pkt_in.box;
    tok_sup  <= pkt_in.tok_sup | hit;
    tok_box  <= pkt_in.tok_box;
    if (store) begin
      entry <= pkt_in.tok_box;
    end
  end

  assign pkt_out = '{box_vld: box_vld, box: box, tok_vld: tok_vld,
                     tok_sup: tok_sup, tok_box: tok_box};

endmodule

@@ src/greedy_box_suppression.sv @@
// A box is taken only while idle; its area is then formed, and the box walks
// the whole chain of MAX_KEPT slot cells, one cell a cycle, ahead of its
// verdict token. The next box is taken only once the verdict is on out_item.
// Reset (rst, synchronous): the kept count goes to zero, the threshold to
// 115, both channels go idle. The kept boxes themselves are not cleared.
module greedy_box_suppression #(
  parameter int MAX_KEPT = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gbs_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gbs_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [gbs_pkg::THR_W-1:0] cfg_data
);
  import gbs_pkg::*;

  localparam int CW = $clog2(MAX_KEPT + 1);

  // Cycles of the walk at which the box and its token enter the chain.
  localparam logic [1:0] INJECT_BOX = 2'd0;
  localparam logic [1:0] INJECT_TOK = 2'd2;
  localparam logic [1:0] WALK_LAST  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_AREA = 4'b0010,
    S_WALK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [1:0]        walk_cnt;
  logic [THR_W-1:0]  thr;
  box_t              cand;
  out_item_t         res;
  logic              keep;
  logic              full;
  pkt_t              link [MAX_KEPT+1];

  assign in_stall = (state != S_IDLE);

  // Feed the chain: the box first at step INJECT_BOX, its token at INJECT_TOK.
  assign link[0] = '{box_vld: (state == S_WALK) && (walk_cnt == INJECT_BOX),
                     box: cand,
                     tok_vld: (state == S_WALK) && (walk_cnt == INJECT_TOK),
                     tok_sup: 1'b0,
                     tok_box: cand};

  // One cell per slot of the kept store.
  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbs_cell #(
      .CW (CW),
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .threshold(thr),
      .count    (count),
      .pkt_in   (link[i]),
      .pkt_out  (link[i+1])
    );
  end

  // Verdict at the end of the chain.
  assign keep       = ~link[MAX_KEPT].tok_sup;
  assign full       = (count == CW'(MAX_KEPT));
  assign count_next = (keep && !full) ? count + CW'(1) : count;

  // Control: sequencer, kept count, threshold and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      walk_cnt  <= '0;
      out_valid <= 1'b0;
      thr       <= THR_RESET;
    end else begin
      if (cfg_we) begin
        thr <= cfg_data;
      end
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.frame_start) begin
              count <= '0;
            end
            state <= S_AREA;
          end
        end
        S_AREA: begin
          walk_cnt <= '0;
          state    <= S_WALK;
        end
        S_WALK: begin
          if (walk_cnt != WALK_LAST) begin
            walk_cnt <= walk_cnt + 2'd1;
          end
          if (link[MAX_KEPT].tok_vld) begin
            count <= count_next;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload: the candidate, its verdict and the output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cand.left   <= in_item.box_left;
      cand.top    <= in_item.box_top;
      cand.width  <= in_item.box_width;
      cand.height <= in_item.box_height;
    end
    if (state == S_AREA) begin
      cand.area <= AREA_W'(cand.width) * AREA_W'(cand.height);
    end
    if (state == S_WALK && link[MAX_KEPT].tok_vld) begin
      res.keep      <= keep;
      res.overflow  <= keep && full;
      res.kept_slot <= SLOT_W'(count_next);
    end
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_item <= res;
    end
  end

endmodule

@@ src/gbs_checker.sv @@
`include "greedy_box_suppression_macros.svh"

module gbs_checker #(
  parameter int MAX_KEPT = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input gbs_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input gbs_pkg::out_item_t out_item
);

  localparam logic [gbs_pkg::SLOT_W-1:0] FULL_SLOT = gbs_pkg::SLOT_W'(MAX_KEPT);

  // A stalled result stays put until it is taken.
  `GBS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_item), "result changed while stalled")

  // Reset leaves no result pending.
  `GBS_ASSERT_RST(a_rst_out, rst |=> !out_valid, "result valid after reset")

  // One box at a time: a transaction on the input that does not start a frame closes the input.
  `GBS_ASSERT(a_one_box, in_valid && !in_stall && !in_item.frame_start |=> in_stall, "second box taken while busy")

  // An overflowing box is always reported against a full store.
  `GBS_ASSERT(a_ovf_full, out_valid && out_item.overflow |-> out_item.keep && out_item.kept_slot == FULL_SLOT, "overflow without a full store")

endmodule

bind greedy_box_suppression gbs_checker #(.MAX_KEPT(MAX_KEPT)) u_gbs_checker (.*);

@@ verif/tb.sv @@
module tb;
  import gbs_pkg::*;

  localparam int BOX_STORE = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BOXES = 90;
  localparam int PHASE_COUNT = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [THR_W-1:0] cfg_data = '0;

  greedy_box_suppression #(
    .MAX_KEPT(BOX_STORE)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  // Free-running clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Shadow copy of the kept-box store and the threshold.
  logic [COORD_W-1:0] held_left [BOX_STORE];
  logic [COORD_W-1:0] held_top [BOX_STORE];
  logic [COORD_W-1:0] held_width [BOX_STORE];
  logic [COORD_W-1:0] held_height [BOX_STORE];
  logic [AREA_W-1:0] held_area [BOX_STORE];
  int held_count = 0;
  logic [THR_W-1:0] iou_limit = THR_RESET;

  out_item_t pending_verdicts [$];
  int verdict_errors = 0;
  int verdicts_checked = 0;
  int verdicts_kept = 0;
  int verdicts_overflow = 0;
  int boxes_sent = 0;
  int thresholds_used = 1;
  int burst_left = 0;
  bit steady = 1'b0;
  int cycle_count = 0;

  // Directed boxes; rows marked typed carry their expected verdict.
  typedef struct packed {
    logic      typed;
    in_item_t  box;
    out_item_t verdict;
  } probe_row_t;

  localparam int PROBE_ROWS = 20;
  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    '{1'b1, '{1'b1, 16'h0000, 16'h0000, 16'h0100, 16'h0100}, '{1'b1, 1'b0, 7'd1}},
    '{1'b1, '{1'b0, 16'h0000, 16'h0000, 16'h0100, 16'h0100}, '{1'b0, 1'b0, 7'd1}},
    '{1'b0, '{1'b0, 16'h0080, 16'h0000, 16'h0100, 16'h0100}, '0},
    '{1'b1, '{1'b0, 16'h0040, 16'h0040, 16'h0000, 16'h0000}, '{1'b1, 1'b0, 7'd3}},
    '{1'b1, '{1'b0, 16'h0040, 16'h0040, 16'h0000, 16'h0000}, '{1'b1, 1'b0, 7'd4}},
    '{1'b0, '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
    '{1'b1, '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '{1'b0, 1'b0, 7'd5}},
    '{1'b0, '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF}, '0},
    '{1'b1, '{1'b1, 16'h0000, 16'h0000, 16'h0100, 16'h0100}, '{1'b1, 1'b0, 7'd1}},
    '{1'b1, '{1'b1, 16'h1234, 16'h0ABC, 16'h0F0F, 16'h00F0}, '{1'b1, 1'b0, 7'd1}},
    '{1'b0, '{1'b0, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}, '0},
    '{1'b0, '{1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}, '0},
    '{1'b0, '{1'b0, 16'h1300, 16'h0000, 16'h0000, 16'hFFFF}, '0},
    '{1'b0, '{1'b0, 16'h1240, 16'h0AC0, 16'h0010, 16'h0010}, '0},
    '{1'b0, '{1'b0, 16'h1238, 16'h0AC0, 16'h0F0F, 16'h00F0}, '0},
    '{1'b1, '{1'b1, 16'h0000, 16'h0000, 16'h0001, 16'h0001}, '{1'b1, 1'b0, 7'd1}},
    '{1'b1, '{1'b0, 16'h0001, 16'h0000, 16'h0001, 16'h0001}, '{1'b1, 1'b0, 7'd2}},
    '{1'b1, '{1'b0, 16'h0000, 16'h0001, 16'h0001, 16'h0001}, '{1'b1, 1'b0, 7'd3}},
    '{1'b0, '{1'b0, 16'h0000, 16'h0000, 16'h0002, 16'h0002}, '0},
    '{1'b0, '{1'b0, 16'h0000, 16'h0000, 16'h0002, 16'h0001}, '0}
  };

  // Length of the overlap of two spans; edges use 17 bits so they never wrap.
  function automatic logic [COORD_W:0] span_overlap(logic [COORD_W-1:0] a0,
                                                    logic [COORD_W-1:0] alen,
                                                    logic [COORD_W-1:0] b0,
                                                    logic [COORD_W-1:0] blen);
    logic [COORD_W:0] lo;
    logic [COORD_W:0] hi;
    logic [COORD_W:0] a_end;
    logic [COORD_W:0] b_end;
    lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    a_end = {1'b0, a0} + {1'b0, alen};
    b_end = {1'b0, b0} + {1'b0, blen};
    hi = (a_end < b_end) ? a_end : b_end;
    return (hi > lo) ? hi - lo : '0;
  endfunction

  // Suppression verdict for one box; updates the shadow store.
  function automatic out_item_t judge_box(in_item_t b);
    logic [AREA_W-1:0] area;
    logic [63:0] inter;
    logic [63:0] uni;
    logic suppressed;
    out_item_t v;
    area = AREA_W'(b.box_width) * AREA_W'(b.box_height);
    if (b.frame_start) begin
      held_count = 0;
    end
    suppressed = 1'b0;
    for (int j = 0; j < held_count; j++) begin
      inter = 64'(span_overlap(b.box_left, b.box_width, held_left[j], held_width[j])) *
              64'(span_overlap(b.box_top, b.box_height, held_top[j], held_height[j]));
      uni = 64'(area) + 64'(held_area[j]) - inter;
      if ((inter << IOU_SHIFT) > 64'(iou_limit) * uni) begin
        suppressed = 1'b1;
      end
    end
    v.keep = ~suppressed;
    v.overflow = 1'b0;
    if (!suppressed) begin
      if (held_count < BOX_STORE) begin
        held_left[held_count] = b.box_left;
        held_top[held_count] = b.box_top;
        held_width[held_count] = b.box_width;
        held_height[held_count] = b.box_height;
        held_area[held_count] = area;
        held_count++;
      end else begin
        v.overflow = 1'b1;
      end
    end
    v.kept_slot = SLOT_W'(held_count);
    return v;
  endfunction

  function automatic logic [COORD_W-1:0] to_coord(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[COORD_W-1:0];
  endfunction

  // Send one box in bursts, with random gaps unless steady, then record its expected verdict.
  task automatic send_box(input in_item_t b, input logic typed, input out_item_t typed_v);
    out_item_t v;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (steady) begin
        gap = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 90);
      end else begin
        gap = $urandom_range(1, 4);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (in_stall);
    v = judge_box(b);
    pending_verdicts.insert(pending_verdicts.size(), typed ? typed_v : v);
    boxes_sent++;
  endtask

  // Stop sending and wait until every verdict has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic load_threshold(input logic [THR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    iou_limit = value;
  endtask

  // Fully random boxes, occasionally with a frame start.
  task automatic noise_burst();
    in_item_t b;
    int n;
    n = $urandom_range(5, 15);
    for (int i = 0; i < n; i++) begin
      b.frame_start = ($urandom_range(0, 5) == 0);
      b.box_left = COORD_W'($urandom);
      b.box_top = COORD_W'($urandom);
      b.box_width = COORD_W'($urandom);
      b.box_height = COORD_W'($urandom);
      send_box(b, 1'b0, '0);
    end
  endtask

  // Disjoint boxes on a grid: all survive, so the store fills and overflows if a frame holds more than BOX_STORE.
  task automatic grid_frame();
    in_item_t b;
    int n;
    int base_x;
    int base_y;
    n = $urandom_range(60, 72);
    base_x = $urandom_range(0, 32768);
    base_y = $urandom_range(0, 32768);
    for (int i = 0; i < n; i++) begin
      b.frame_start = (i == 0);
      b.box_left = to_coord(base_x + (i % 16) * 1024 + int'($urandom_range(0, 511)));
      b.box_top = to_coord(base_y + (i / 16) * 1024 + int'($urandom_range(0, 511)));
      b.box_width = COORD_W'($urandom_range(1, 512));
      b.box_height = COORD_W'($urandom_range(1, 512));
      send_box(b, 1'b0, '0);
    end
  endtask

  // Jittered copies of a few objects, giving overlaps around the threshold.
  task automatic cluster_frame();
    in_item_t b;
    int n;
    int centers;
    int c;
    int cx [4];
    int cy [4];
    int cw [4];
    int ch [4];
    n = $urandom_range(5, 30);
    centers = $urandom_range(1, 4);
    for (int i = 0; i < centers; i++) begin
      cw[i] = $urandom_range(16, 4096);
      ch[i] = $urandom_range(16, 4096);
      cx[i] = $urandom_range(0, 65535 - cw[i]);
      cy[i] = $urandom_range(0, 65535 - ch[i]);
    end
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, centers - 1);
      // Most frames clear the store; the rest keep piling onto it.
      b.frame_start = (i == 0) && ($urandom_range(0, 3) != 0);
      b.box_left = to_coord(cx[c] + int'($urandom_range(0, cw[c] / 2)) - cw[c] / 4);
      b.box_top = to_coord(cy[c] + int'($urandom_range(0, ch[c] / 2)) - ch[c] / 4);
      b.box_width = to_coord(cw[c] * int'($urandom_range(70, 130)) / 100);
      b.box_height = to_coord(ch[c] * int'($urandom_range(70, 130)) / 100);
      if ($urandom_range(0, 15) == 0) begin
        b.box_width = '0;
      end
      send_box(b, 1'b0, '0);
    end
  endtask

  // Receiver stall pattern: off, light, heavy and periodic stretches.
  logic [15:0] stall_tick = '0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 16'd1;
    case (stall_tick[10:9])
      2'd0: begin
        out_stall <= 1'b0;
      end
      2'd1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2'd2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= stall_tick[3] ^ stall_tick[5];
      end
    endcase
  end

  // Compare each accepted verdict with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      verdicts_checked++;
      if (out_item.keep === 1'b1) verdicts_kept++;
      if (out_item.overflow === 1'b1) verdicts_overflow++;
      if (pending_verdicts.size() == 0) begin
        verdict_errors++;
        if (verdict_errors <= 10) begin
          $display("ERROR: unexpected verdict keep=%b overflow=%b slot=%0d",
                   out_item.keep, out_item.overflow, out_item.kept_slot);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (out_item.keep !== want.keep || out_item.overflow !== want.overflow ||
            out_item.kept_slot !== want.kept_slot) begin
          verdict_errors++;
          if (verdict_errors <= 10) begin
            $display("ERROR: verdict %0d: expected keep/overflow/slot %b/%b/%0d, got %b/%b/%0d",
                     verdicts_checked, want.keep, want.overflow, want.kept_slot,
                     out_item.keep, out_item.overflow, out_item.kept_slot);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d verdicts outstanding",
             cycle_count, pending_verdicts.size());
    $display("Mismatches found");
    $finish;
  end

  // Main sequence: reset, directed boxes, then random phases per threshold.
  initial begin
    logic [THR_W-1:0] limit_plan [PHASE_COUNT];
    int phase_start;
    int pick;
    limit_plan = '{9'd0, 9'd256, 9'd128, 9'd1, 9'd255, 9'd0, 9'd115};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed transactions at the reset threshold.
    for (int r = 0; r < PROBE_ROWS; r++) begin
      send_box(PROBES[r].box, PROBES[r].typed, PROBES[r].verdict);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      if (p == 5) begin
        limit_plan[p] = THR_W'($urandom_range(2, 254));
      end
      load_threshold(limit_plan[p]);
      thresholds_used++;
      steady = ($urandom_range(0, 2) == 0);
      phase_start = boxes_sent;
      while (boxes_sent - phase_start < PHASE_BOXES) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          cluster_frame();
        end else if (pick < 7) begin
          grid_frame();
        end else begin
          noise_burst();
        end
      end
    end

    // Let the pipeline empty, then watch for stray verdicts.
    drain();
    repeat (BOX_STORE + 20) @(posedge clk);
    $display("Sent %0d boxes over %0d threshold settings; %0d verdicts checked",
             boxes_sent, thresholds_used, verdicts_checked);
    $display("Verdicts: %0d kept, %0d suppressed, %0d kept with full store",
             verdicts_kept, verdicts_checked - verdicts_kept, verdicts_overflow);
    if (verdict_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
